// ----- hw/rtl/subarray_or_coverage_counter_macros.svh -----
// Assertion macros shared by the subarray OR coverage counter RTL.
`ifndef SUBARRAY_OR_COVERAGE_COUNTER_MACROS_SVH
`define SUBARRAY_OR_COVERAGE_COUNTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCOC_ASSERT_IMPLIES(name, ck, rn, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCOC_ASSERT_NEXT(name, ck, rn, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hw/rtl/scoc_pkg.sv -----
// Shared types and constants for the subarray OR coverage counter.
package scoc_pkg;

  // Fixed widths of the channel fields
  localparam int WORD_IN_W   = 10;
  localparam int COUNT_OUT_W = 10;

  // Generation tag kept per seen-map entry
  localparam int EPOCH_BITS = 4;
  typedef logic [EPOCH_BITS-1:0] epoch_t;
  localparam epoch_t EPOCH_ONE = epoch_t'(1);
  localparam epoch_t EPOCH_MAX = {EPOCH_BITS{1'b1}};

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  // Control handed to the cell chain each cycle
  typedef struct packed {
    logic pop;
    logic push;
    logic flush;
  } chain_ctrl_t;

endpackage

// ----- hw/rtl/scoc_cell.sv -----
// One cell of the OR-list chain: holds one list entry.
module scoc_cell #(
  parameter int W = 10
) (
  input  logic         clk,
  input  logic         pop,
  input  logic         load,
  input  logic [W-1:0] nb_val,
  input  logic [W-1:0] load_val,
  output logic [W-1:0] val
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  // Advance from the neighbor on a pop, take the new entry when this cell is the tail
  always_comb begin
    val_nxt = val_r;
    if (pop) begin
      val_nxt = nb_val;
    end
    if (load) begin
      val_nxt = load_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- hw/rtl/scoc_chain.sv -----
// Row of list cells forming a shift queue: old entries leave at the head, new ones enter at the tail.
module scoc_chain #(
  parameter int W     = 10,
  parameter int DEPTH = 12,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scoc_pkg::chain_ctrl_t ctrl,
  input  logic [W-1:0]          cand,
  output logic [W-1:0]          head,
  output logic [CNT_W-1:0]      count
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] tail;
  logic [W-1:0]     vals [DEPTH];

  // Tail slot after this cycle's pop
  assign tail = count_r - CNT_W'(ctrl.pop);

  // Track occupancy
  always_comb begin
    count_nxt = count_r - CNT_W'(ctrl.pop) + CNT_W'(ctrl.push);
    if (ctrl.flush) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Build the row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] nb;
    logic         load;

    if (i == DEPTH - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = vals[i+1];
    end

    assign load = ctrl.push && (tail == CNT_W'(i));

    scoc_cell #(
      .W (W)
    ) u_cell (
      .clk      (clk),
      .pop      (ctrl.pop),
      .load     (load),
      .nb_val   (nb),
      .load_val (cand),
      .val      (vals[i])
    );
  end

  assign head  = vals[0];
  assign count = count_r;

endmodule

// ----- hw/rtl/scoc_seen.sv -----
// Seen map: one generation tag per value, read-first single-port memory.
module scoc_seen #(
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                en,
  input  logic [ADDR_W-1:0]   addr,
  input  scoc_pkg::epoch_t    wr_tag,
  input  scoc_pkg::epoch_t    cur_epoch,
  output logic                hit
);

  import scoc_pkg::*;

  localparam int MAP_DEPTH = 1 << ADDR_W;

  epoch_t mem [MAP_DEPTH];
  epoch_t rd_tag_r;

  // Read the old tag and write the new one at the same address
  always_ff @(posedge clk) begin
    if (en) begin
      rd_tag_r  <= mem[addr];
      mem[addr] <= wr_tag;
    end
  end

  // Entry counts as seen when its tag matches the live generation
  assign hit = (rd_tag_r == cur_epoch);

endmodule

// ----- hw/rtl/subarray_or_coverage_counter.sv -----
// Top level of the subarray OR coverage counter.
//
// Input channel: in_word / in_last with in_valid and in_stall. Each word
// extends the list of distinct ORs of runs ending at it; every list value
// is marked in a seen map and new nonzero values bump a running count.
// On a word with in_last set, one output word carries out_covered_count
// and out_all_covered (every nonzero value seen), and all state clears.
// Throughput: a word is accepted in idle, then its run walks the previous
// word's list of L entries (at most VALUE_BITS+1): the list queue pops one
// old entry per cycle through the cell chain and the seen memory takes one
// mark per cycle on its single port; in_stall stays high until the run ends.
// Latency: after the last word's list steps, the emit state loads the output
// register once the output is free, so a word with in_last set keeps
// in_stall high until the result is handed over.
// After reset, and again after every 15th sequence when the generation
// tag wraps, the seen memory is swept with in_stall held high.
// The output is a register; while out_stall holds it, the block
// still takes input words and only waits when the next result is ready.
`include "subarray_or_coverage_counter_macros.svh"

module subarray_or_coverage_counter #(
  parameter int VALUE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [scoc_pkg::WORD_IN_W-1:0]   in_word,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [scoc_pkg::COUNT_OUT_W-1:0] out_covered_count,
  output logic                             out_all_covered
);

  import scoc_pkg::*;

  localparam int LIST_DEPTH  = VALUE_BITS + 1;
  localparam int CHAIN_DEPTH = VALUE_BITS + 2;
  localparam int CNT_W       = $clog2(CHAIN_DEPTH + 1);
  localparam int N_W         = $clog2(LIST_DEPTH + 1);
  localparam logic [VALUE_BITS-1:0] ADDR_MAX = {VALUE_BITS{1'b1}};

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   x_r, x_nxt;
  logic                    last_r, last_nxt;
  logic                    first_r, first_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [VALUE_BITS-1:0]   last_push_r, last_push_nxt;
  logic [N_W-1:0]          new_n_r, new_n_nxt;
  logic [VALUE_BITS-1:0]   running_count_r, running_count_nxt;
  epoch_t                  epoch_r, epoch_nxt;
  logic [VALUE_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic                    mark_v_r, mark_v_nxt;
  logic                    mark_nz_r, mark_nz_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [COUNT_OUT_W-1:0]  out_count_r, out_count_nxt;
  logic                    out_all_r, out_all_nxt;

  chain_ctrl_t             ctrl;
  logic [VALUE_BITS-1:0]   cand;
  logic [VALUE_BITS-1:0]   head;
  logic [CNT_W-1:0]        chain_count;
  logic                    mem_en;
  logic [VALUE_BITS-1:0]   mem_addr;
  epoch_t                  mem_wdata;
  logic                    seen_hit;
  logic                    accept;
  logic                    run_done;
  logic                    emit_fire;
  logic                    out_free;
  logic                    tally_inc;
  logic [VALUE_BITS-1:0]   cnt_sum;
  logic [VALUE_BITS+WORD_IN_W-1:0]   word_wide;
  logic [VALUE_BITS+COUNT_OUT_W-1:0] cnt_wide;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_MAX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_done) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = (epoch_r == EPOCH_MAX) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs: chain control, memory port, emit strobe
  always_comb begin
    ctrl      = '0;
    mem_en    = 1'b0;
    mem_addr  = '0;
    mem_wdata = epoch_r;
    run_done  = 1'b0;
    emit_fire = 1'b0;
    cand      = first_r ? x_r : (head | x_r);
    case (state_r)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        ctrl = '0;
      end
      ST_RUN: begin
        ctrl.pop  = !first_r;
        ctrl.push = (first_r || (cand != last_push_r)) &&
                    (new_n_r < N_W'(LIST_DEPTH));
        mem_en    = ctrl.push;
        mem_addr  = cand;
        run_done  = first_r ? (rem_r == '0) : (rem_r == CNT_W'(1));
      end
      ST_EMIT: begin
        emit_fire  = out_free;
        ctrl.flush = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  // Tally the mark issued last cycle
  assign tally_inc = mark_v_r && mark_nz_r && !seen_hit;
  assign cnt_sum   = running_count_r + VALUE_BITS'(tally_inc);
  assign cnt_wide  = (VALUE_BITS + COUNT_OUT_W)'(cnt_sum);
  assign word_wide = (VALUE_BITS + WORD_IN_W)'(in_word);

  // Datapath next values
  always_comb begin
    x_nxt             = x_r;
    last_nxt          = last_r;
    first_nxt         = first_r;
    rem_nxt           = rem_r;
    last_push_nxt     = last_push_r;
    new_n_nxt         = new_n_r;
    running_count_nxt = cnt_sum;
    epoch_nxt         = epoch_r;
    clr_addr_nxt      = clr_addr_r;
    mark_v_nxt        = ctrl.push;
    mark_nz_nxt       = (cand != '0);
    out_valid_nxt     = out_valid_r && out_stall;
    out_count_nxt     = out_count_r;
    out_all_nxt       = out_all_r;

    // Latch the word and snapshot the old list length
    if (accept) begin
      x_nxt     = word_wide[VALUE_BITS-1:0];
      last_nxt  = in_last;
      first_nxt = 1'b1;
      rem_nxt   = chain_count;
      new_n_nxt = '0;
    end

    // Step through the old list
    if (state_r == ST_RUN) begin
      first_nxt = 1'b0;
      if (!first_r) begin
        rem_nxt = rem_r - CNT_W'(1);
      end
      if (ctrl.push) begin
        last_push_nxt = cand;
        new_n_nxt     = new_n_r + N_W'(1);
      end
    end

    // Sweep the seen memory
    if (state_r == ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + VALUE_BITS'(1);
      if (clr_addr_r == ADDR_MAX) begin
        epoch_nxt = EPOCH_ONE;
      end
    end

    // Hand over the result and drop the sequence state
    if (emit_fire) begin
      out_valid_nxt     = 1'b1;
      out_count_nxt     = cnt_wide[COUNT_OUT_W-1:0];
      out_all_nxt       = (cnt_sum == ADDR_MAX);
      running_count_nxt = '0;
      if (epoch_r != EPOCH_MAX) begin
        epoch_nxt = epoch_r + EPOCH_ONE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      first_r         <= 1'b0;
      rem_r           <= '0;
      new_n_r         <= '0;
      running_count_r <= '0;
      epoch_r         <= EPOCH_ONE;
      clr_addr_r      <= '0;
      mark_v_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      first_r         <= first_nxt;
      rem_r           <= rem_nxt;
      new_n_r         <= new_n_nxt;
      running_count_r <= running_count_nxt;
      epoch_r         <= epoch_nxt;
      clr_addr_r      <= clr_addr_nxt;
      mark_v_r        <= mark_v_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    last_r      <= last_nxt;
    last_push_r <= last_push_nxt;
    mark_nz_r   <= mark_nz_nxt;
    out_count_r <= out_count_nxt;
    out_all_r   <= out_all_nxt;
  end

  scoc_chain #(
    .W     (VALUE_BITS),
    .DEPTH (CHAIN_DEPTH)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .cand  (cand),
    .head  (head),
    .count (chain_count)
  );

  scoc_seen #(
    .ADDR_W (VALUE_BITS)
  ) u_seen (
    .clk       (clk),
    .en        (mem_en),
    .addr      (mem_addr),
    .wr_tag    (mem_wdata),
    .cur_epoch (epoch_r),
    .hit       (seen_hit)
  );

  assign out_valid         = out_valid_r;
  assign out_covered_count = out_count_r;
  assign out_all_covered   = out_all_r;

  // Check sequencing invariants
  `SCOC_ASSERT_NEXT(a_clear_ends_idle, clk, rst_n,
    state_r == ST_CLEAR && clr_addr_r == ADDR_MAX,
    state_r == ST_IDLE && epoch_r == EPOCH_ONE,
    "sweep did not end in idle with first generation")
  `SCOC_ASSERT_IMPLIES(a_run_epoch_live, clk, rst_n,
    state_r == ST_RUN, epoch_r != '0,
    "marking with the swept generation tag")
  `SCOC_ASSERT_IMPLIES(a_tally_after_run, clk, rst_n,
    mark_v_r, $past(state_r) == ST_RUN,
    "tally pending without a list step")
  `SCOC_ASSERT_IMPLIES(a_idle_list_fits, clk, rst_n,
    state_r == ST_IDLE, chain_count <= CNT_W'(LIST_DEPTH),
    "stored list exceeds its bound")
  `SCOC_ASSERT_NEXT(a_emit_loads_out, clk, rst_n,
    state_r == ST_EMIT && out_free, out_valid_r && chain_count == '0,
    "emit did not load output or flush list")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the subarray OR coverage counter.
`timescale 1ns / 1ps

module tb_top;
  import scoc_pkg::*;

  localparam int VALUE_BITS   = 10;
  localparam int CHAIN_DEPTH  = VALUE_BITS + 1;
  localparam int MAP_SIZE     = 1 << VALUE_BITS;
  localparam logic [WORD_IN_W-1:0] VALUE_MASK = WORD_IN_W'(MAP_SIZE - 1);
  localparam int DIRECTED_ROWS = 23;
  localparam int TOTAL_WORDS   = 1350;
  localparam int CALM_WORDS    = 150;
  localparam int PRESSURE_AT   = 350;
  localparam int PRESSURE_LEN  = 50;
  localparam int DRAIN_AT      = 750;
  localparam int LONG_HOLD     = 300;
  localparam int TAIL_CYCLES   = 40;
  localparam int LIMIT_NS      = 10_000_000;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count;
    logic                   all;
  } cover_result_t;

  typedef struct packed {
    logic [WORD_IN_W-1:0]   word;
    logic                   fin;
    logic                   typed;
    logic [COUNT_OUT_W-1:0] want_count;
    logic                   want_all;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [WORD_IN_W-1:0]   in_word;
  logic                   in_last;
  logic                   out_valid;
  logic                   out_stall;
  logic [COUNT_OUT_W-1:0] out_covered_count;
  logic                   out_all_covered;

  // Model state: OR chain of runs ending at the latest word, seen map, count
  logic [WORD_IN_W-1:0] or_runs [0:CHAIN_DEPTH-1];
  int unsigned          run_count;
  bit                   value_seen [0:MAP_SIZE-1];
  int unsigned          new_values;

  cover_result_t due_counts[$];
  stim_row_t     directed_rows [0:DIRECTED_ROWS-1];

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned sequences_sent;
  int unsigned results_checked;
  int unsigned full_cover_seen;
  int unsigned longest_chain;
  bit          calm;
  bit          hold_request;
  int unsigned holds_done;

  subarray_or_coverage_counter #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_word          (in_word),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_covered_count(out_covered_count),
    .out_all_covered  (out_all_covered)
  );

  // Generate a 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clear the chain, the seen map and the count
  function automatic void clear_coverage();
    int i;
    for (i = 0; i < CHAIN_DEPTH; i++) or_runs[i] = '0;
    for (i = 0; i < MAP_SIZE; i++) value_seen[i] = 1'b0;
    run_count  = 0;
    new_values = 0;
  endfunction

  // Advance the OR chain by one word; return 1 when a count word is due
  function automatic bit or_chain_step(input logic [WORD_IN_W-1:0] w, input bit fin,
                                       output cover_result_t res);
    logic [WORD_IN_W-1:0] nxt [0:CHAIN_DEPTH-1];
    logic [WORD_IN_W-1:0] v;
    int unsigned          n;
    int                   i;
    n = 1;
    nxt[0] = w & VALUE_MASK;
    for (i = 0; i < run_count; i++) begin
      v = (or_runs[i] | nxt[0]) & VALUE_MASK;
      if (v != nxt[n-1] && n < CHAIN_DEPTH) begin
        nxt[n] = v;
        n++;
      end
    end
    // Mark every chain value; zero is marked but never counted
    for (i = 0; i < n; i++) begin
      if (!value_seen[nxt[i]]) begin
        value_seen[nxt[i]] = 1'b1;
        if (nxt[i] != '0) new_values++;
      end
    end
    for (i = 0; i < CHAIN_DEPTH; i++) or_runs[i] = (i < n) ? nxt[i] : '0;
    run_count = n;
    if (n > longest_chain) longest_chain = n;
    res = '0;
    if (!fin) return 1'b0;
    res.count = new_values[COUNT_OUT_W-1:0];
    res.all   = (new_values == MAP_SIZE - 1);
    clear_coverage();
    return 1'b1;
  endfunction

  // Pick a word: mostly random, often sparse, sometimes the extremes
  function automatic logic [WORD_IN_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return VALUE_MASK;
      2, 3:    return WORD_IN_W'(1) << $urandom_range(0, WORD_IN_W - 1);
      4:       return (WORD_IN_W'(1) << $urandom_range(0, WORD_IN_W - 1)) |
                      (WORD_IN_W'(1) << $urandom_range(0, WORD_IN_W - 1));
      default: return WORD_IN_W'($urandom_range(0, MAP_SIZE - 1));
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("MISMATCH at result %0d, %s: got %0d, want %0d",
             results_checked, what, got, want);
    mismatches++;
  endtask

  // Drop the input valid for a number of cycles
  task automatic sender_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one word, hold it until accepted, then record what it predicts
  task automatic push_word(input logic [WORD_IN_W-1:0] w, input bit fin, input bit typed,
                           input cover_result_t typed_res);
    cover_result_t res;
    bit            due;
    in_valid <= 1'b1;
    in_word  <= w;
    in_last  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = or_chain_step(w, fin, res);
    if (due) due_counts.insert(due_counts.size(), typed ? typed_res : res);
    words_sent++;
    if (fin) sequences_sent++;
  endtask

  // Check each accepted count word against the oldest expectation
  always @(posedge clk) begin
    cover_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_counts.size() == 0) begin
        flag_mismatch("count word with none expected", 32'(out_covered_count), 0);
      end else begin
        want = due_counts.pop_front();
        if (out_covered_count !== want.count)
          flag_mismatch("covered_count", 32'(out_covered_count), 32'(want.count));
        if (out_all_covered !== want.all)
          flag_mismatch("all_covered", 32'(out_all_covered), 32'(want.all));
        if (out_all_covered === 1'b1) full_cover_seen++;
      end
      results_checked++;
    end
  end

  // Stall the output in bursts, with one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // End the run if the block hangs
  initial begin
    #(LIMIT_NS);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned   r;
    int unsigned   k;
    int unsigned   seq_len;
    int unsigned   pick;
    bit            bursty;
    bit            pressure_done;
    bit            drain_done;
    cover_result_t typed_res;

    mismatches      = 0;
    words_sent      = 0;
    sequences_sent  = 0;
    results_checked = 0;
    full_cover_seen = 0;
    longest_chain   = 0;
    holds_done      = 0;
    calm            = 1'b0;
    hold_request    = 1'b0;
    pressure_done   = 1'b0;
    drain_done      = 1'b0;
    clear_coverage();

    // Directed words: zero alone, extremes, repeats, growing chains
    directed_rows = '{
      '{10'd0,    1'b1, 1'b1, 10'd0, 1'b0},
      '{10'd1023, 1'b1, 1'b1, 10'd1, 1'b0},
      '{10'd1,    1'b1, 1'b1, 10'd1, 1'b0},
      '{10'd0,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd0,    1'b1, 1'b1, 10'd0, 1'b0},
      '{10'd1,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd2,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd4,    1'b1, 1'b0, 10'd0, 1'b0},
      '{10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
      '{10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd1023, 1'b1, 1'b1, 10'd1, 1'b0},
      '{10'd0,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd1,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd2,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd4,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd8,    1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd16,   1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd32,   1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd64,   1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd128,  1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd256,  1'b0, 1'b0, 10'd0, 1'b0},
      '{10'd512,  1'b1, 1'b0, 10'd0, 1'b0}
    };

    // Hold reset, then release it; the block then sweeps its seen memory
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    in_last  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      typed_res.count = directed_rows[r].want_count;
      typed_res.all   = directed_rows[r].want_all;
      push_word(directed_rows[r].word, directed_rows[r].fin, directed_rows[r].typed,
                typed_res);
      if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 12));
    end

    // Random sequences of random length and content
    typed_res = '0;
    while (words_sent < TOTAL_WORDS) begin
      calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);

      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        // Short sequences back to back while the output is held off
        hold_request = 1'b1;
        for (k = 0; k < PRESSURE_LEN; k++)
          push_word(pick_word(), $urandom_range(0, 1) == 1 || k == PRESSURE_LEN - 1,
                    1'b0, typed_res);
        pressure_done = 1'b1;
        continue;
      end

      if (!drain_done && words_sent >= DRAIN_AT) begin
        // Wait for every outstanding count word
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_counts.size() != 0) @(posedge clk);
        drain_done = 1'b1;
      end

      pick = $urandom_range(0, 19);
      if (pick < 14)      seq_len = $urandom_range(1, 12);
      else if (pick < 19) seq_len = $urandom_range(13, 40);
      else                seq_len = $urandom_range(41, 90);
      bursty = !calm && $urandom_range(0, 2) != 0;

      for (k = 0; k < seq_len; k++) begin
        if (bursty && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 12));
        push_word(pick_word(), k == seq_len - 1, 1'b0, typed_res);
      end
    end

    // Drain outstanding count words, then let the pipeline settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_counts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d sequences; checked %0d count words, %0d fully covered.",
             words_sent, sequences_sent, results_checked, full_cover_seen);
    $display("Longest OR chain %0d entries; long output holds %0d; mismatches %0d.",
             longest_chain, holds_done, mismatches);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
